// ===== design/lfps_pkg.sv =====
`timescale 1ns / 1ps
package lfps_pkg;
   localparam int unsigned ERR_W = 16;
   localparam int unsigned SUM_W = 25;
   localparam logic signed [ERR_W-1:0] ONE_Q = 16'sd256;
   localparam logic signed [ERR_W-1:0] ESCAPE_ERR = 16'sd384;
   localparam logic [6:0] SLOW_DUTY = 7'd20;
   localparam logic [6:0] FAST_DUTY = 7'd45;

   localparam logic [2:0] REG_MODE_IR     = 3'd0;
   localparam logic [2:0] REG_LEFT_THR    = 3'd1;
   localparam logic [2:0] REG_RIGHT_THR   = 3'd2;
   localparam logic [2:0] REG_BEACON_THR  = 3'd3;
   localparam logic [2:0] REG_GAIN_P      = 3'd4;
   localparam logic [2:0] REG_GAIN_I      = 3'd5;
   localparam logic [2:0] REG_GAIN_D      = 3'd6;
   localparam logic [2:0] REG_INT_LIMIT   = 3'd7;

   // multiply operand selectors
   typedef enum logic [1:0] {
      MUL_ERR_DT,
      MUL_P,
      MUL_I,
      MUL_D
   } mul_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic        load;      // capture input word, classify
      logic        mul_go;    // multiply with mul_sel
      mul_sel_type mul_sel;
      logic        div_start; // start derivative divide
      logic        div_step;  // one restoring step
      logic        div_done;  // apply sign to quotient, clamp integral
      logic        finish;    // form outputs, update state
   } lfps_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic dt_zero;
   } lfps_sts_type;
endpackage

// ===== design/line_follow_pid_steering_top.sv =====
`timescale 1ns / 1ps
// Line-follow steering PID. Each req word (left/right sample, elapsed ms,
// escape pulse) yields one rsp word (servo angle, motor duties, Q8.8 steer
// value, zero-time flag). One word is in flight at a time; from accept to rsp
// valid it passes a classify step, an err*dt multiply, a 17-step restoring
// divider for the derivative plus a sign and integral-clamp step, three
// passes through the shared multiplier for the P, I and D terms (D skipped
// when elapsed time is zero), and an output step. req_tready returns once the
// rsp register is loaded, so a new word is not taken before the last is done;
// a stalled rsp word holds the last step until it drains. The rsp register
// holds a finished word while the next req is already being worked on. Config
// writes via csr_ are accepted every cycle and must only occur while idle.
module line_follow_pid_steering_top
   import lfps_pkg::*;
#(
   parameter int CENTER_ANGLE = 90,
   parameter int LOW_ANGLE    = 45,
   parameter int HIGH_ANGLE   = 135,
   parameter int CRUISE_SPEED = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_sample[15:0], right_sample[31:16], elapsed_ms[47:32], escape_event[48]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // servo_angle[7:0], left_speed[14:8], right_speed[21:15],
   // steer_value[37:22], time_fault[38]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   logic        mode_ir_ff;
   logic [15:0] left_thr_ff, right_thr_ff, beacon_thr_ff;
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [23:0] int_limit_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ir_ff    <= 1'b0;
         left_thr_ff   <= 16'd2048;
         right_thr_ff  <= 16'd2048;
         beacon_thr_ff <= 16'd1000;
         gain_p_ff     <= 16'd256;
         gain_i_ff     <= 16'd0;
         gain_d_ff     <= 16'd0;
         int_limit_ff  <= 24'd256000;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE_IR:    mode_ir_ff    <= csr_data[0];
            REG_LEFT_THR:   left_thr_ff   <= csr_data[15:0];
            REG_RIGHT_THR:  right_thr_ff  <= csr_data[15:0];
            REG_BEACON_THR: beacon_thr_ff <= csr_data[15:0];
            REG_GAIN_P:     gain_p_ff     <= csr_data[15:0];
            REG_GAIN_I:     gain_i_ff     <= csr_data[15:0];
            REG_GAIN_D:     gain_d_ff     <= csr_data[15:0];
            REG_INT_LIMIT:  int_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   lfps_cmd_type cmd;
   lfps_sts_type sts;
   logic busy, out_load, out_free;
   logic valid_ff;

   assign req_tready = !busy;
   // output register frees when empty or being taken this cycle
   assign out_free   = !valid_ff || rsp_tready;

   lfps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_tvalid && req_tready),
      .sts(sts), .out_free(out_free), .cmd(cmd), .busy(busy), .out_load(out_load)
   );

   logic [7:0] servo_angle;
   logic [6:0] left_speed, right_speed;
   logic signed [15:0] steer_value;
   logic time_fault;

   lfps_dp #(
      .CENTER_ANGLE(CENTER_ANGLE), .LOW_ANGLE(LOW_ANGLE),
      .HIGH_ANGLE(HIGH_ANGLE), .CRUISE_SPEED(CRUISE_SPEED)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .left_sample(req_tdata[15:0]), .right_sample(req_tdata[31:16]),
      .elapsed_ms(req_tdata[47:32]), .escape_event(req_tdata[48]),
      .mode_ir(mode_ir_ff), .left_thr(left_thr_ff), .right_thr(right_thr_ff),
      .beacon_thr(beacon_thr_ff), .gain_p(gain_p_ff), .gain_i(gain_i_ff),
      .gain_d(gain_d_ff), .int_limit(int_limit_ff),
      .servo_angle(servo_angle), .left_speed(left_speed), .right_speed(right_speed),
      .steer_value(steer_value), .time_fault(time_fault)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (out_load) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, time_fault, steer_value, right_speed, left_speed,
                        servo_angle};
endmodule

// ===== design/lfps_ctrl.sv =====
`timescale 1ns / 1ps
module lfps_ctrl
   import lfps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  lfps_sts_type sts,
   input  logic         out_free,
   output lfps_cmd_type cmd,
   output logic         busy,
   output logic         out_load
);
   typedef enum logic [2:0] {
      S_IDLE, S_MULDT, S_DIV, S_MULP, S_MULI, S_MULD, S_FIN
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_ERR_DT;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MULDT;
            end
         end
         S_MULDT: begin
            cmd.mul_go    = 1'b1;
            cmd.mul_sel   = MUL_ERR_DT;
            cmd.div_start = 1'b1;
            cnt_in        = 5'd0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == 5'd17) begin
               cmd.div_done = 1'b1;
               state_in     = S_MULP;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 5'd1;
            end
         end
         S_MULP: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_P;
            state_in    = S_MULI;
         end
         S_MULI: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_I;
            state_in    = S_MULD;
         end
         S_MULD: begin
            // zero elapsed time: no derivative term, accumulator kept
            cmd.mul_go  = !sts.dt_zero;
            cmd.mul_sel = MUL_D;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               out_load   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule

// ===== design/lfps_dp.sv =====
`timescale 1ns / 1ps
module lfps_dp
   import lfps_pkg::*;
#(
   parameter int CENTER_ANGLE = 90,
   parameter int LOW_ANGLE    = 45,
   parameter int HIGH_ANGLE   = 135,
   parameter int CRUISE_SPEED = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  lfps_cmd_type cmd,
   output lfps_sts_type sts,
   input  logic [15:0]  left_sample,
   input  logic [15:0]  right_sample,
   input  logic [15:0]  elapsed_ms,
   input  logic         escape_event,
   input  logic         mode_ir,
   input  logic [15:0]  left_thr,
   input  logic [15:0]  right_thr,
   input  logic [15:0]  beacon_thr,
   input  logic [15:0]  gain_p,
   input  logic [15:0]  gain_i,
   input  logic [15:0]  gain_d,
   input  logic [23:0]  int_limit,
   output logic [7:0]   servo_angle,
   output logic [6:0]   left_speed,
   output logic [6:0]   right_speed,
   output logic signed [15:0] steer_value,
   output logic         time_fault
);
   localparam logic signed [19:0] BASE_Q = 20'(CENTER_ANGLE * 256);
   localparam logic signed [19:0] HI_OFF = 20'((HIGH_ANGLE - CENTER_ANGLE) * 256);
   localparam logic signed [19:0] LO_OFF = 20'((LOW_ANGLE - CENTER_ANGLE) * 256);

   logic signed [15:0] last_err_ff, last_err_in, err_ff, err_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic esc_ff, esc_in, diff_ff, diff_in;
   logic [15:0] dt_ff;
   logic signed [16:0] delta_ff;
   logic signed [42:0] acc_ff;
   // divider
   logic [16:0] rem_ff;
   logic [16:0] quo_ff;
   logic        qneg_ff;
   logic signed [17:0] deriv_ff;

   // classification
   always_comb begin
      logic signed [16:0] d;
      logic [16:0] ad;
      logic signed [17:0] dbl;
      logic l_off, r_off, l_on, r_on;
      esc_in  = esc_ff | escape_event;
      diff_in = 1'b0;
      err_in  = last_err_ff;
      l_off = left_sample > left_thr;
      r_off = right_sample > right_thr;
      l_on  = left_sample < left_thr;
      r_on  = right_sample < right_thr;
      d  = $signed({1'b0, left_sample}) - $signed({1'b0, right_sample});
      ad = d[16] ? 17'(-d) : 17'(d);
      dbl = 18'(last_err_ff) <<< 1;
      if (!mode_ir) begin
         priority if (esc_in) err_in = ESCAPE_ERR;
         else if (l_off && r_off) begin
            diff_in = 1'b1;
            if (dbl > 18'sd32767) err_in = 16'sh7fff;
            else if (dbl < -18'sd32768) err_in = 16'sh8000;
            else err_in = dbl[15:0];
         end else if (l_off && r_on) begin
            err_in = -ONE_Q; esc_in = 1'b0;
         end else if (l_on && r_off) begin
            err_in = ONE_Q; esc_in = 1'b0;
         end else begin
            err_in = '0; esc_in = 1'b0;
         end
      end else begin
         priority if (!d[16] && 17'(d) > {1'b0, beacon_thr}) err_in = ONE_Q;
         else if (d[16] && ad > {1'b0, beacon_thr}) err_in = -ONE_Q;
         else if (ad < {1'b0, beacon_thr}) err_in = '0;
         else err_in = last_err_ff;
      end
   end

   // shared 17x26 signed multiplier
   logic signed [25:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [42:0] prod;
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ERR_DT: begin mul_a = 26'(err_ff); mul_b = $signed({1'b0, dt_ff}); end
         MUL_P: begin mul_a = 26'(err_ff); mul_b = $signed({1'b0, gain_p}); end
         MUL_I: begin mul_a = 26'(sum_ff); mul_b = $signed({1'b0, gain_i}); end
         MUL_D: begin mul_a = 26'(deriv_ff); mul_b = $signed({1'b0, gain_d}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod = 43'(mul_a) * 43'(mul_b);
   end

   // integral clamp from registered err*dt product
   logic signed [33:0] sum_new;
   logic signed [33:0] lim_s;
   logic signed [SUM_W-1:0] sum_cl;
   assign lim_s   = $signed({10'd0, int_limit});
   assign sum_new = 34'(sum_ff) + 34'(acc_ff);
   always_comb begin
      priority if (sum_new > lim_s) sum_cl = SUM_W'(lim_s);
      else if (sum_new < -lim_s) sum_cl = SUM_W'(-lim_s);
      else sum_cl = SUM_W'(sum_new);
   end

   // restoring divide step on magnitudes
   logic [16:0] rem_sh, rem_sub;
   assign rem_sh  = {rem_ff[15:0], quo_ff[16]};
   assign rem_sub = rem_sh - {1'b0, dt_ff};

   // output shaping
   logic signed [42:0] pid_fl;
   logic signed [19:0] pid_c;
   logic signed [19:0] ang_q;
   always_comb begin
      pid_fl = acc_ff >>> 8;
      if (pid_fl > 43'(HI_OFF)) pid_c = HI_OFF;
      else if (pid_fl < 43'(LO_OFF)) pid_c = LO_OFF;
      else pid_c = 20'(pid_fl);
      if (pid_c > 20'sd32767) pid_c = 20'sd32767;
      else if (pid_c < -20'sd32768) pid_c = -20'sd32768;
      ang_q = BASE_Q + pid_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         sum_ff      <= '0;
         esc_ff      <= 1'b0;
      end else begin
         if (cmd.load) begin
            err_ff   <= err_in;
            esc_ff   <= esc_in;
            diff_ff  <= diff_in;
            dt_ff    <= elapsed_ms;
            delta_ff <= 17'(err_in) - 17'(last_err_ff);
         end
         if (cmd.mul_go) begin
            unique case (cmd.mul_sel)
               MUL_ERR_DT, MUL_P: acc_ff <= prod;
               default:           acc_ff <= acc_ff + prod;
            endcase
         end
         if (cmd.div_start) begin
            qneg_ff <= delta_ff[16];
            quo_ff  <= delta_ff[16] ? 17'(-delta_ff) : 17'(delta_ff);
            rem_ff  <= '0;
         end
         if (cmd.div_step) begin
            if (!rem_sub[16]) rem_ff <= rem_sub;
            else rem_ff <= rem_sh;
            quo_ff <= {quo_ff[15:0], ~rem_sub[16]};
         end
         if (cmd.div_done) begin
            deriv_ff <= qneg_ff ? -18'($signed({1'b0, quo_ff})) : 18'($signed({1'b0, quo_ff}));
            // acc holds err*dt for the whole divide
            sum_ff   <= sum_cl;
         end
         if (cmd.finish) begin
            last_err_ff <= err_ff;
            steer_value <= pid_c[15:0];
            time_fault  <= (dt_ff == '0);
            if (pid_c == '0) begin
               servo_angle <= 8'(CENTER_ANGLE);
               left_speed  <= 7'(CRUISE_SPEED);
               right_speed <= 7'(CRUISE_SPEED);
            end else begin
               servo_angle <= ang_q[19] ? 8'd0 : ang_q[15:8];
               if (!diff_ff) begin
                  left_speed  <= 7'(CRUISE_SPEED);
                  right_speed <= 7'(CRUISE_SPEED);
               end else if (pid_c[19]) begin
                  left_speed  <= FAST_DUTY;
                  right_speed <= SLOW_DUTY;
               end else begin
                  left_speed  <= SLOW_DUTY;
                  right_speed <= FAST_DUTY;
               end
            end
         end
      end
   end

   assign sts.dt_zero = (dt_ff == '0);
endmodule

// ===== design/lfps_checker.sv =====
`timescale 1ns / 1ps
module lfps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   // a word is accepted only after the previous finished
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp dropped while stalled");
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] <= 8'd180))
      else $error("servo angle out of range");
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("rsp without work");
endmodule

bind line_follow_pid_steering_top lfps_checker u_lfps_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
